// File: rtl/pss_pkg.sv
// ============================================================================
// Periodic stream scheduler package
// Shared types, codes and sizes for the scheduler table, engine and top level.
// ============================================================================
package pss_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W    = 16;
    localparam int MS_W    = 16;

    localparam logic [MS_W-1:0] TICK_STEP_RESET = MS_W'(10);

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SENT    = 3'd1,
        ST_UPDATED = 3'd2,
        ST_ADDED   = 3'd3,
        ST_REMOVED = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] var_id;
        logic [MS_W-1:0] period;
        logic [MS_W-1:0] timer;
    } entry_t;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] var_id;
        logic [MS_W-1:0] period_ms;
    } item_t;

    typedef struct packed {
        logic            sent;
        logic [ID_W-1:0] sent_var_id;
        status_t         status;
    } result_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

endpackage

// File: rtl/periodic_stream_scheduler.sv
// ============================================================================
// Periodic stream scheduler
// Table of periodic send entries driven by tick and update beats.
// ----------------------------------------------------------------------------
// Every input beat on the s_ channel is either a tick (s_tuser = 0) or a
// table update (s_tuser = 1) and yields exactly one result beat on m_.
// A tick adds tick_step to every timer and reports the lowest enabled entry
// whose timer has reached its period; an update adds, changes or removes an
// entry by variable id and reports the outcome in the status field.
// The engine walks all 16 entries with a read and a write-back step each,
// since the table memory has one port shared by reads and writes. An update
// that claims a free entry reads and writes it once more after the walk.
// One beat is processed at a time; s_tready is high while the engine
// waits for work. Results go to an output register, so a new beat is
// accepted while the previous result waits for m_tready. If the receiver
// stalls further, the engine holds its finished result and stops taking
// input. The user writes tick_step through cfg_valid/cfg_data only while
// the block is idle; the block itself does not enforce this. After reset
// the table is empty and tick_step is 10.
// ============================================================================
module periodic_stream_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // var_id[15:0], period_ms[31:16]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sent_var_id[15:0]
    output logic [3:0]  m_tuser,   // sent[0], status[3:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [pss_pkg::MS_W-1:0] tick_step_reg;
    logic                     out_valid_reg;
    pss_pkg::result_t         out_reg;

    pss_pkg::item_t    in_item;
    pss_pkg::result_t  res;
    pss_pkg::mem_req_t req;
    pss_pkg::entry_t   rd_data;
    logic              res_valid;
    logic              res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_step_reg <= pss_pkg::TICK_STEP_RESET;
        end else if (cfg_valid) begin
            tick_step_reg <= cfg_data;
        end
    end

    assign in_item.cmd       = s_tuser[0];
    assign in_item.var_id    = s_tdata[15:0];
    assign in_item.period_ms = s_tdata[31:16];

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sent_var_id;
    assign m_tuser  = {out_reg.status, out_reg.sent};

    pss_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_step (tick_step_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .req       (req),
        .rd_data   (rd_data)
    );

    pss_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/pss_table.sv
// ============================================================================
// Scheduler entry table
// Synchronous entry memory with a registered read. Per-entry valid bits
// make entries that were never written read as an empty entry after reset.
// ============================================================================
module pss_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  pss_pkg::mem_req_t req,
    output pss_pkg::entry_t   rd_data
);

    pss_pkg::entry_t mem [pss_pkg::ENTRIES];
    logic [pss_pkg::ENTRIES-1:0] valid_reg;
    pss_pkg::entry_t data_reg;
    logic            data_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                data_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = data_valid_reg ? data_reg : '0;

endmodule

// File: rtl/pss_engine.sv
// ============================================================================
// Scheduler engine
// Sequencer that walks the entry table once per item with read-modify-write
// and, for an add, claims the first free entry in a second short access.
// ============================================================================
module pss_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pss_pkg::MS_W-1:0]      tick_step,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pss_pkg::item_t                in_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output pss_pkg::result_t              res,
    output pss_pkg::mem_req_t             req,
    input  pss_pkg::entry_t               rd_data
);

    typedef enum logic [5:0] {
        S_IDLE        = 6'b000001,
        S_READ        = 6'b000010,
        S_MODIFY      = 6'b000100,
        S_CLAIM_READ  = 6'b001000,
        S_CLAIM_WRITE = 6'b010000,
        S_DONE        = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [pss_pkg::IDX_W-1:0]    idx_reg, idx_next;
    pss_pkg::item_t               item_reg, item_next;
    logic                         found_reg, found_next;
    logic                         free_found_reg, free_found_next;
    logic [pss_pkg::IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [pss_pkg::ID_W-1:0]     sent_id_reg, sent_id_next;

    logic [pss_pkg::MS_W-1:0] timer_sum;
    logic                     id_match;
    logic                     last_entry;
    logic                     tick_hit;
    pss_pkg::entry_t          wr_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg        <= idx_next;
        item_reg       <= item_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        sent_id_reg    <= sent_id_next;
    end

    assign timer_sum  = rd_data.timer + tick_step;
    assign id_match   = (rd_data.var_id == item_reg.var_id);
    assign last_entry = (idx_reg == pss_pkg::IDX_W'(pss_pkg::ENTRIES - 1));
    assign tick_hit   = !found_reg && rd_data.en && (rd_data.period != '0)
                        && (timer_sum >= rd_data.period);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        item_next       = item_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        sent_id_next    = sent_id_reg;
        wr_entry        = rd_data;
        req             = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next       = in_item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    sent_id_next    = '0;
                    state_next      = S_READ;
                end
            end
            S_READ: begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg;
                state_next  = S_MODIFY;
            end
            S_MODIFY: begin
                if (item_reg.cmd == pss_pkg::CMD_TICK) begin
                    wr_entry.timer = tick_hit ? '0 : timer_sum;
                    if (tick_hit) begin
                        found_next   = 1'b1;
                        sent_id_next = rd_data.var_id;
                    end
                end else if (item_reg.period_ms == '0) begin
                    if (id_match) begin
                        wr_entry.en     = 1'b0;
                        wr_entry.period = '0;
                    end
                end else begin
                    if (id_match && !found_reg) begin
                        wr_entry.en     = 1'b1;
                        wr_entry.period = item_reg.period_ms;
                        found_next      = 1'b1;
                    end
                    if (!rd_data.en && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                end
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = wr_entry;
                if (last_entry) begin
                    if ((item_reg.cmd == pss_pkg::CMD_UPDATE) && (item_reg.period_ms != '0)
                        && !found_next && free_found_next) begin
                        state_next = S_CLAIM_READ;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_CLAIM_READ: begin
                req.rd_en   = 1'b1;
                req.rd_addr = free_idx_reg;
                state_next  = S_CLAIM_WRITE;
            end
            S_CLAIM_WRITE: begin
                wr_entry.en     = 1'b1;
                wr_entry.var_id = item_reg.var_id;
                wr_entry.period = item_reg.period_ms;
                req.wr_en       = 1'b1;
                req.wr_addr     = free_idx_reg;
                req.wr_data     = wr_entry;
                state_next      = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.sent        = (item_reg.cmd == pss_pkg::CMD_TICK) && found_reg;
        res.sent_var_id = sent_id_reg;
        if (item_reg.cmd == pss_pkg::CMD_TICK) begin
            res.status = found_reg ? pss_pkg::ST_SENT : pss_pkg::ST_IDLE;
        end else if (item_reg.period_ms == '0) begin
            res.status = pss_pkg::ST_REMOVED;
        end else if (found_reg) begin
            res.status = pss_pkg::ST_UPDATED;
        end else if (free_found_reg) begin
            res.status = pss_pkg::ST_ADDED;
        end else begin
            res.status = pss_pkg::ST_FULL;
        end
    end

    a_no_read_write_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.rd_en && req.wr_en))
        else $error("table read and write issued in the same cycle");

    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> $past(req.rd_en))
        else $error("table write without a preceding read");

    a_walk_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> req.rd_en && (req.rd_addr == '0))
        else $error("table walk did not start at entry zero");

    a_sent_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.sent == (res.status == pss_pkg::ST_SENT)))
        else $error("sent flag disagrees with status");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result dropped or changed");

endmodule

// File: bench/tb.sv
// ============================================================================
// Periodic stream scheduler testbench
// Drives tick and update beats into the scheduler, predicts every result from
// a local copy of the send table and tick step, and compares each result beat
// field by field in order. Random idling and a long receiver stall are mixed
// in, and the tick step is rewritten between phases while the block is idle.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 188;

    class sched_scoreboard;
        pss_pkg::entry_t          slots[pss_pkg::ENTRIES];
        logic [pss_pkg::MS_W-1:0] step;
        pss_pkg::result_t         expected_q[$];
        int                       errors;

        function new();
            int k;
            for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                slots[k] = '0;
            end
            step   = pss_pkg::TICK_STEP_RESET;
            errors = 0;
        endfunction

        function void note_input(pss_pkg::item_t it);
            pss_pkg::result_t r;
            bit               done;
            int               k;
            r.sent        = 1'b0;
            r.sent_var_id = '0;
            done          = 1'b0;
            if (it.cmd == pss_pkg::CMD_TICK) begin
                r.status = pss_pkg::ST_IDLE;
                for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                    slots[k].timer = slots[k].timer + step;
                end
                for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                    if (!done && slots[k].en && slots[k].period != '0 &&
                        slots[k].timer >= slots[k].period) begin
                        slots[k].timer = '0;
                        r.sent         = 1'b1;
                        r.sent_var_id  = slots[k].var_id;
                        r.status       = pss_pkg::ST_SENT;
                        done           = 1'b1;
                    end
                end
            end else if (it.period_ms == '0) begin
                for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                    if (slots[k].var_id == it.var_id) begin
                        slots[k].period = '0;
                        slots[k].en     = 1'b0;
                    end
                end
                r.status = pss_pkg::ST_REMOVED;
            end else begin
                r.status = pss_pkg::ST_FULL;
                for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                    if (!done && slots[k].var_id == it.var_id) begin
                        slots[k].period = it.period_ms;
                        slots[k].en     = 1'b1;
                        r.status        = pss_pkg::ST_UPDATED;
                        done            = 1'b1;
                    end
                end
                for (k = 0; k < pss_pkg::ENTRIES; k++) begin
                    if (!done && !slots[k].en) begin
                        slots[k].var_id = it.var_id;
                        slots[k].period = it.period_ms;
                        slots[k].en     = 1'b1;
                        r.status        = pss_pkg::ST_ADDED;
                        done            = 1'b1;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(pss_pkg::result_t got);
            pss_pkg::result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: sent %0d id %0h status %0d",
                       got.sent, got.sent_var_id, got.status);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.sent !== want.sent) begin
                    $error("sent: expected %0d, actual %0d", want.sent, got.sent);
                    errors++;
                end
                if (got.sent_var_id !== want.sent_var_id) begin
                    $error("sent_var_id: expected %0h, actual %0h",
                           want.sent_var_id, got.sent_var_id);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    sched_scoreboard sb;
    bit              quiet;
    bit              hold_req;
    int              stall_cycles;

    periodic_stream_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Beat monitor and watchdog, both sampling at the rising edge.
    always @(posedge aclk) begin
        pss_pkg::item_t   it;
        pss_pkg::result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.sent        = m_tuser[0];
                got.status      = pss_pkg::status_t'(m_tuser[3:1]);
                got.sent_var_id = m_tdata;
                sb.check_result(got);
            end
            if (s_tvalid && s_tready) begin
                it.cmd       = s_tuser[0];
                it.var_id    = s_tdata[15:0];
                it.period_ms = s_tdata[31:16];
                sb.note_input(it);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[periodic_stream_scheduler] ERROR");
                $finish;
            end
        end
    end

    // Result receiver with random back-pressure and one long hold-off.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic cmd, input logic [15:0] id,
                             input logic [15:0] per);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {per, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_tick_step(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.step = value;
    endtask

    task automatic random_phase(input int count, input int hold_at);
        int          n;
        int          pick;
        logic [15:0] id;
        logic [15:0] per;
        for (n = 0; n < count; n++) begin
            if (n == hold_at) begin
                hold_req = 1'b1;
            end
            pick = $urandom_range(0, 99);
            id   = 16'($urandom_range(0, 23));
            per  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
            if (pick < 55) begin
                send_beat(pss_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                send_beat(pss_pkg::CMD_UPDATE, id, per);
            end else if (pick < 93) begin
                send_beat(pss_pkg::CMD_UPDATE, id, 16'h0000);
            end else begin
                send_beat(pss_pkg::CMD_UPDATE, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        int k;
        sb           = new();
        quiet        = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= pss_pkg::CMD_TICK;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: stale id 0 match, send, extremes, removals, full table.
        send_beat(pss_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
        send_beat(pss_pkg::CMD_UPDATE, 16'h0000, 16'h0001);
        send_beat(pss_pkg::CMD_TICK, 16'h0000, 16'h0000);
        send_beat(pss_pkg::CMD_UPDATE, 16'hFFFF, 16'hFFFF);
        send_beat(pss_pkg::CMD_UPDATE, 16'h1234, 16'h0000);
        send_beat(pss_pkg::CMD_UPDATE, 16'hFFFF, 16'h0005);
        send_beat(pss_pkg::CMD_UPDATE, 16'h0000, 16'h0000);
        for (k = 1; k < pss_pkg::ENTRIES; k++) begin
            send_beat(pss_pkg::CMD_UPDATE, 16'(k), 16'(k * 7));
        end
        send_beat(pss_pkg::CMD_UPDATE, 16'hAAAA, 16'h0003);
        send_beat(pss_pkg::CMD_TICK, 16'h5555, 16'hAAAA);
        send_beat(pss_pkg::CMD_UPDATE, 16'hFFFF, 16'h0000);

        random_phase(PHASE_ITEMS, -1);
        write_tick_step(16'h0001);
        random_phase(PHASE_ITEMS, 60);
        write_tick_step(16'h0000);
        random_phase(PHASE_ITEMS, -1);
        write_tick_step(16'hFFFF);
        random_phase(PHASE_ITEMS, -1);
        write_tick_step(16'($urandom));
        random_phase(PHASE_ITEMS, -1);
        write_tick_step(pss_pkg::TICK_STEP_RESET);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS, -1);

        drain();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[periodic_stream_scheduler] OK");
        end else begin
            $display("[periodic_stream_scheduler] ERROR");
        end
        $finish;
    end

endmodule
